### sv/i2a_pkg.sv
// Package for the integer to ASCII formatter.
// Holds the character constants, the controller/datapath word types and the digit encoder.
// No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

	localparam int WORD_W = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W = NUM_DIGITS * 4;
	localparam int IDX_W = $clog2(NUM_DIGITS);
	localparam int CNT_W = $clog2(WORD_W);

	localparam logic CMD_DEC = 1'b0;
	localparam logic CMD_HEX = 1'b1;

	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_ALPHA = 8'h41;
	localparam logic [7:0] CHR_MINUS = 8'h2D;

	typedef struct packed {
		logic load;
		logic shift;
		logic seek;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic hex;
		logic idx_zero;
	} dp_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHR_ZERO + {4'b0, d};
		end else begin
			c = CHR_ALPHA + {4'b0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

### sv/i2a_ctrl.sv
// Controller of the integer to ASCII formatter.
// Sequences load, binary to BCD shifting, digit search and character emission.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_ctrl import i2a_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl,
	output logic     busy
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SEEK  = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_DIGIT = 5'b10000
	} state_t;

	state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;

	always_comb begin
		state_n = state_q;
		cnt_n = cnt_q;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					cnt_n = CNT_W'(WORD_W - 1);
					state_n = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.hex) begin
					state_n = ST_SEEK;
				end else begin
					ctl.shift = 1'b1;
					if (cnt_q == '0) begin
						state_n = ST_SEEK;
					end else begin
						cnt_n = cnt_q - 1'b1;
					end
				end
			end
			ST_SEEK: begin
				ctl.seek = 1'b1;
				state_n = stat.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				ctl.emit_sign = 1'b1;
				state_n = ST_DIGIT;
			end
			ST_DIGIT: begin
				ctl.emit_digit = 1'b1;
				if (stat.idx_zero) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_n;
			cnt_q <= cnt_n;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### sv/i2a_dp.sv
// Datapath of the integer to ASCII formatter.
// Holds the magnitude and BCD registers, the digit pointer and the registered output word.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_dp import i2a_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           ctl,
	input  logic              cmd,
	input  logic [WORD_W-1:0] number,
	output dp_stat_t          stat,
	output logic [7:0]        char_code,
	output logic              last,
	output logic              strobe
);

	logic [WORD_W-1:0] mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  lead;
	logic [3:0]        nib;
	logic              neg_q;
	logic              hex_q;
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] > 4'd4) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				lead = IDX_W'(i);
			end
		end
	end

	assign nib = bcd_q[idx_q*4 +: 4];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hex_q <= (cmd == CMD_HEX);
			if (cmd == CMD_HEX) begin
				neg_q <= 1'b0;
				mag_q <= number;
				bcd_q <= {{(BCD_W - WORD_W){1'b0}}, number};
			end else begin
				neg_q <= number[WORD_W-1];
				mag_q <= number[WORD_W-1] ? (~number + 1'b1) : number;
				bcd_q <= '0;
			end
		end else if (ctl.shift) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[WORD_W-1]};
			mag_q <= {mag_q[WORD_W-2:0], 1'b0};
		end
		if (ctl.seek) begin
			idx_q <= lead;
		end else if (ctl.emit_digit) begin
			idx_q <= idx_q - 1'b1;
		end
		if (ctl.emit_sign) begin
			char_q <= CHR_MINUS;
			last_q <= 1'b0;
		end else if (ctl.emit_digit) begin
			char_q <= digit_char(nib);
			last_q <= (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit_sign | ctl.emit_digit;
		end
	end

	assign stat.neg = neg_q;
	assign stat.hex = hex_q;
	assign stat.idx_zero = (idx_q == '0);
	assign char_code = char_q;
	assign last = last_q;
	assign strobe = strobe_q;

endmodule

### sv/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Joins the controller and the datapath; depends on i2a_pkg, i2a_ctrl and i2a_dp.
//
// Usage:
// An input word (cmd, number) is taken at a rising edge where start is high and
// busy is low. cmd low prints number as signed decimal, cmd high as upper-case hex.
// The characters leave most significant first, each on char_code for one cycle
// with strobe high; last marks the final character of the number. A negative
// decimal number begins with a minus sign, and zero prints as a single '0'.
// Decimal conversion shifts the word through a 10-digit BCD register, one bit a
// cycle, before the first character appears; hex skips the shifting. Characters
// then follow one per cycle. A word gives at most 11 characters, and busy stays
// high until the last character is issued.
// The receiver cannot stall and must take each character as it comes.
// Reset puts the block idle with strobe low; no state survives between words.
`timescale 1ns / 1ps

module integer_to_ascii_formatter import i2a_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [WORD_W-1:0] number,
	output logic              strobe,
	output logic [7:0]        char_code,
	output logic              last
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	i2a_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	i2a_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd       (cmd),
		.number    (number),
		.stat      (stat),
		.char_code (char_code),
		.last      (last),
		.strobe    (strobe)
	);

endmodule

### sv/i2a_chk.sv
// Port checker for the integer to ASCII formatter, bound to the top level.
// Depends on i2a_pkg and integer_to_ascii_formatter.
`timescale 1ns / 1ps

module i2a_chk import i2a_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              cmd,
	input logic [WORD_W-1:0] number,
	input logic              strobe,
	input logic [7:0]        char_code,
	input logic              last
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word issued right after the final character");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final character while idle");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy fell without the final character");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHR_MINUS) ||
			((char_code >= CHR_ZERO) && (char_code <= CHR_ZERO + 8'd9)) ||
			((char_code >= CHR_ALPHA) && (char_code <= CHR_ALPHA + 8'd5)))
		else $error("character code out of range");

endmodule

bind integer_to_ascii_formatter i2a_chk u_chk (.*);

### tb/sv/tb_top.sv
// Testbench for integer_to_ascii_formatter: drives words in decimal and hex mode and
// checks every character and its last flag against given text or a behavioral model.
// Depends on i2a_pkg and the integer_to_ascii_formatter RTL.
`timescale 1ns / 1ps

module tb_top;
	import i2a_pkg::*;

	localparam int RANDOM_WORDS = 129;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [7:0] code;
		logic       fin;
	} char_slot_t;

	// A zero text means the expected characters come from the model below.
	typedef struct packed {
		logic        sel;
		logic [31:0] value;
		logic [87:0] text;
	} dir_row_t;

	localparam int NUM_DIRECTED = 21;
	localparam dir_row_t DIRECTED_WORDS [NUM_DIRECTED] = '{
		'{CMD_DEC, 32'h0000_0000, "0"},
		'{CMD_HEX, 32'h0000_0000, "0"},
		'{CMD_DEC, 32'h8000_0000, "-2147483648"},
		'{CMD_DEC, 32'h7FFF_FFFF, "2147483647"},
		'{CMD_DEC, 32'hFFFF_FFFF, "-1"},
		'{CMD_HEX, 32'hFFFF_FFFF, "FFFFFFFF"},
		'{CMD_HEX, 32'h8000_0000, "80000000"},
		'{CMD_HEX, 32'h7FFF_FFFF, "7FFFFFFF"},
		'{CMD_DEC, 32'd1, "1"},
		'{CMD_DEC, 32'd9, "9"},
		'{CMD_DEC, 32'd10, "10"},
		'{CMD_DEC, 32'hFFFF_FFF6, "-10"},
		'{CMD_DEC, 32'd1000000000, "1000000000"},
		'{CMD_DEC, 32'd0 - 32'd1000000000, "-1000000000"},
		'{CMD_HEX, 32'h0000_0009, "9"},
		'{CMD_HEX, 32'h0000_000F, "F"},
		'{CMD_HEX, 32'h0000_0010, "10"},
		'{CMD_HEX, 32'hABCD_EF01, "ABCDEF01"},
		'{CMD_HEX, 32'h0123_4567, 88'h0},
		'{CMD_DEC, 32'd123456789, 88'h0},
		'{CMD_DEC, 32'hC000_0000, 88'h0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cmd;
	logic [WORD_W-1:0] number;
	logic              strobe;
	logic [7:0]        char_code;
	logic              last;

	char_slot_t expected_chars[$];
	int         fault_count = 0;
	int         quiet_cycles = 0;
	int         idle_pct = 26;

	integer_to_ascii_formatter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.number   (number),
		.strobe   (strobe),
		.char_code(char_code),
		.last     (last)
	);

	always #5 clk = ~clk;

	function automatic void spell_number(input logic sel, input logic [31:0] value);
		logic [31:0] mag;
		logic [31:0] base;
		logic [31:0] d;
		logic [7:0]  digs [11];
		int          nd;
		mag = value;
		nd = 0;
		if (sel == CMD_DEC && value[31]) begin
			mag = 32'd0 - value;
			expected_chars.push_back(char_slot_t'{CHR_MINUS, 1'b0});
		end
		base = (sel == CMD_HEX) ? 32'd16 : 32'd10;
		do begin
			d = mag % base;
			mag = mag / base;
			digs[nd] = (d < 32'd10) ? CHR_ZERO + d[7:0] : CHR_ALPHA + d[7:0] - 8'd10;
			nd++;
		end while (mag != 0 && nd < 11);
		for (int i = nd - 1; i >= 0; i--) begin
			expected_chars.push_back(char_slot_t'{digs[i], i == 0});
		end
	endfunction

	function automatic void spell_text(input logic [87:0] text);
		for (int b = 10; b >= 0; b--) begin
			if (text[b*8 +: 8] != 8'h00) begin
				expected_chars.push_back(char_slot_t'{text[b*8 +: 8], b == 0});
			end
		end
	endfunction

	function automatic logic [31:0] random_number();
		logic [31:0] v;
		int          k;
		case ($urandom_range(0, 5))
			0, 1: begin
				v = $urandom;
			end
			2: begin
				v = $urandom_range(0, 20);
			end
			3: begin
				v = 32'd0 - $urandom_range(1, 1000);
			end
			4: begin
				v = 32'd1;
				k = $urandom_range(0, 9);
				repeat (k) v = v * 32'd10;
				v = v + $urandom_range(0, 2) - 32'd1;
			end
			default: begin
				v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
			end
		endcase
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic sel, input logic [31:0] value, input logic [87:0] text);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			cmd <= 1'($urandom_range(0, 1));
			number <= $urandom;
			do begin
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end while ($urandom_range(0, 99) < idle_pct);
		end
		start <= 1'b1;
		cmd <= sel;
		number <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (text != 88'h0) begin
			spell_text(text);
		end else begin
			spell_number(sel, value);
		end
		@(negedge clk);
	endtask

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					note_fault($sformatf("unexpected character '%c' last %0d", char_code, last));
				end else begin
					if (char_code !== expected_chars[0].code || last !== expected_chars[0].fin) begin
						note_fault($sformatf("expected '%c' last %0d, got '%c' (%h) last %0d",
							expected_chars[0].code, expected_chars[0].fin, char_code, char_code,
							last));
					end
					void'(expected_chars.pop_front());
				end
			end
			if (strobe || (start && !busy)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_DEC;
		number = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_WORDS[i]) begin
			send_word(DIRECTED_WORDS[i].sel, DIRECTED_WORDS[i].value, DIRECTED_WORDS[i].text);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i < RANDOM_WORDS / 3) begin
				idle_pct = 26;
			end else if (i < 2 * RANDOM_WORDS / 3) begin
				idle_pct = 55;
			end else begin
				idle_pct = 0;
			end
			send_word(1'($urandom_range(0, 1)), random_number(), 88'h0);
		end
		start <= 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
sv/i2a_pkg.sv
sv/i2a_ctrl.sv
sv/i2a_dp.sv
sv/integer_to_ascii_formatter.sv
sv/i2a_chk.sv
tb/sv/tb_top.sv
